@@ src/cspe_pkg.sv @@
package cspe_pkg;

	typedef logic signed [31:0] coord_t;

	typedef struct packed {
		coord_t coord_x;
		coord_t coord_y;
		coord_t coord_z;
		logic   final_point;
	} point_t;

	typedef struct packed {
		coord_t position_x;
		coord_t position_y;
		coord_t position_z;
		coord_t tangent_x;
		coord_t tangent_y;
		coord_t tangent_z;
		coord_t curvature_x;
		coord_t curvature_y;
		coord_t curvature_z;
		logic   last_sample;
	} sample_t;

	localparam int FRAMES_W = 7;
	localparam logic [FRAMES_W-1:0] FRAMES_RESET = 7'd16;
	localparam logic [FRAMES_W-1:0] MAX_FRAMES = 7'd64;
	localparam int QUEUE_DEPTH_DEF = 2;

	// segment job: four points, oldest first, and the settings taken at accept
	typedef struct packed {
		coord_t [3:0][2:0]   pts;
		logic                mode;
		logic [FRAMES_W-1:0] frames;
	} job_t;

	// apb register map
	localparam int ADDR_W = 3;
	localparam logic REG_MODE = 1'b0;
	localparam logic REG_FRAMES = 1'b1;

	localparam logic MODE_CATMULL = 1'b0;
	localparam logic MODE_BSPLINE = 1'b1;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_SQR,
		BK_CUBE,
		BK_ORD,
		BK_DRAIN,
		BK_LOAD
	} back_state_t;

	// reciprocals of 3 for the b-spline scaling
	localparam logic [16:0] RECIP3_17 = 17'd43691;
	localparam logic [18:0] RECIP3_20 = 19'd349526;

	// [mode][order][point][coef of u^3, u^2, u, 1]
	localparam int BASIS [2][3][4][4] = '{
		'{
			'{'{-1, 2, -1, 0}, '{3, -5, 0, 2}, '{-3, 4, 1, 0}, '{1, -1, 0, 0}},
			'{'{0, -3, 4, -1}, '{0, 9, -10, 0}, '{0, -9, 8, 1}, '{0, 3, -2, 0}},
			'{'{0, 0, -6, 4}, '{0, 0, 18, -10}, '{0, 0, -18, 8}, '{0, 0, 6, -2}}
		},
		'{
			'{'{-1, 3, -3, 1}, '{3, -6, 0, 4}, '{-3, 3, 3, 1}, '{1, 0, 0, 0}},
			'{'{0, -3, 6, -3}, '{0, 9, -12, 0}, '{0, -9, 6, 3}, '{0, 3, 0, 0}},
			'{'{0, 0, -6, 6}, '{0, 0, 18, -12}, '{0, 0, -18, 6}, '{0, 0, 6, 0}}
		}
	};

	// basis weight in q.24, rounded from the exact q.48 polynomial
	function automatic coord_t weight_q24(logic mode, logic [1:0] ord, logic [1:0] pt,
			logic [15:0] u, logic [31:0] u2, logic [47:0] u3);
		logic signed [5:0]  c3, c2, c1, c0;
		logic signed [56:0] e3, e2, e1, e0, w, r;
		c3 = 6'(BASIS[mode][ord][pt][0]);
		c2 = 6'(BASIS[mode][ord][pt][1]);
		c1 = 6'(BASIS[mode][ord][pt][2]);
		c0 = 6'(BASIS[mode][ord][pt][3]);
		e3 = $signed(57'(u3));
		e2 = $signed(57'({u2, 16'b0}));
		e1 = $signed(57'({u, 32'b0}));
		e0 = 57'sd1 <<< 48;
		w = c3 * e3 + c2 * e2 + c1 * e1 + c0 * e0;
		r = (w + (57'sd1 <<< 23)) >>> 24;
		return r[31:0];
	endfunction

endpackage

@@ src/cubic_spline_point_evaluator.sv @@
// a point that completes a segment queues a job; the back end takes one job at a time,
// divides 65536 by the frame count by restoring division, then per sample squares and
// cubes u, issues the three orders to the shared pipeline, drains it, loads the sample;
// points that only fill the window are taken one per cycle while the job queue has room
// reset: arst_n clears window count, queue, sequencer and output valid; mode 0, frames 16
module cubic_spline_point_evaluator
	import cspe_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// control point channel
	input  logic              point_valid,
	output logic              point_ready,
	input  point_t            point,
	// sample channel
	output logic              sample_valid,
	input  logic              sample_ready,
	output sample_t           sample,
	// register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic                mode_q;
	logic [FRAMES_W-1:0] frames_q;
	logic                reg_wr;
	logic                reg_idx;

	// front to back job transfer
	logic job_valid, job_ready;
	job_t job;
	logic back_busy;

	assign pready = 1'b1;
	assign reg_idx = paddr[2];
	// a register write completes on the access phase
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CATMULL;
			frames_q <= FRAMES_RESET;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_MODE: mode_q <= pwdata[0];
				REG_FRAMES: frames_q <= pwdata[FRAMES_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MODE: prdata = {31'b0, mode_q};
			REG_FRAMES: prdata = {{(32 - FRAMES_W){1'b0}}, frames_q};
			default: prdata = '0;
		endcase
	end

	// front: window of held points, classifies each point, queues segment jobs
	cspe_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.point_valid       (point_valid),
		.point_ready       (point_ready),
		.point             (point),
		.spline_mode       (mode_q),
		.frames_per_segment(frames_q),
		.job_valid         (job_valid),
		.job_ready         (job_ready),
		.job               (job)
	);

	// back: steps u through the segment and evaluates all three orders per sample
	cspe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (job_valid),
		.job_ready   (job_ready),
		.job         (job),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample      (sample),
		.busy        (back_busy)
	);

`ifndef SYNTHESIS
	// a taken job always starts the sequencer
	a_job_starts: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && job_ready |=> back_busy)
		else $error("job transfer did not start the back end");

	// the back end only wakes on a queued job
	a_busy_from_job: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(back_busy) |-> $past(job_valid))
		else $error("back end started without a job");

	// queued frame counts are already clamped
	a_frames_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> (job.frames != '0) && (job.frames <= MAX_FRAMES))
		else $error("unclamped frame count in job queue");
`endif

endmodule

@@ src/cspe_front.sv @@
module cspe_front
	import cspe_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                point_valid,
	output logic                point_ready,
	input  point_t              point,
	input  logic                spline_mode,
	input  logic [FRAMES_W-1:0] frames_per_segment,
	output logic                job_valid,
	input  logic                job_ready,
	output job_t                job
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             q_mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	coord_t           win_q [9];
	logic [1:0]       held_q;

	logic                accept, push, pop;
	logic [FRAMES_W-1:0] frames_clamped;
	job_t                new_job;

	assign point_ready = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign accept = point_valid && point_ready;
	assign push = accept && (held_q == 2'd3);
	assign job_valid = (cnt_q != '0);
	assign pop = job_valid && job_ready;
	assign job = q_mem_q[rd_ptr_q];

	always_comb begin
		if (frames_per_segment == '0) begin
			frames_clamped = FRAMES_W'(1);
		end else if (frames_per_segment > MAX_FRAMES) begin
			frames_clamped = MAX_FRAMES;
		end else begin
			frames_clamped = frames_per_segment;
		end
		for (int p = 0; p < 3; p++) begin
			for (int k = 0; k < 3; k++) begin
				new_job.pts[p][k] = win_q[p * 3 + k];
			end
		end
		new_job.pts[3][0] = point.coord_x;
		new_job.pts[3][1] = point.coord_y;
		new_job.pts[3][2] = point.coord_z;
		new_job.mode = spline_mode;
		new_job.frames = frames_clamped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
			held_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (accept) begin
				if (point.final_point) begin
					held_q <= '0;
				end else if (held_q != 2'd3) begin
					held_q <= held_q + 1'b1;
				end
			end
		end
	end

	// point window and queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= new_job;
		end
		if (accept) begin
			if (held_q == 2'd3) begin
				for (int i = 0; i < 6; i++) begin
					win_q[i] <= win_q[i + 3];
				end
				win_q[6] <= point.coord_x;
				win_q[7] <= point.coord_y;
				win_q[8] <= point.coord_z;
			end else begin
				unique case (held_q)
					2'd0: begin
						win_q[0] <= point.coord_x;
						win_q[1] <= point.coord_y;
						win_q[2] <= point.coord_z;
					end
					2'd1: begin
						win_q[3] <= point.coord_x;
						win_q[4] <= point.coord_y;
						win_q[5] <= point.coord_z;
					end
					default: begin
						win_q[6] <= point.coord_x;
						win_q[7] <= point.coord_y;
						win_q[8] <= point.coord_z;
					end
				endcase
			end
		end
	end

endmodule

@@ src/cspe_back.sv @@
module cspe_back
	import cspe_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    job_valid,
	output logic    job_ready,
	input  job_t    job,
	output logic    sample_valid,
	input  logic    sample_ready,
	output sample_t sample,
	output logic    busy
);

	back_state_t state_q, state_d;
	job_t        job_q;
	logic [4:0]  cnt_q;
	logic [6:0]  rem_q;
	logic [16:0] quo_q;
	logic [16:0] u_q;
	logic [6:0]  ur_q;
	logic [6:0]  idx_q;
	logic [31:0] u2_q;
	logic [47:0] u3_q;
	logic [1:0]  ord_q;

	logic                     vld_s1, vld_s2, vld_s3, vld_s4;
	logic [1:0]               ord_s1, ord_s2, ord_s3, ord_s4;
	coord_t                   w_s1 [4];
	logic signed [63:0]       prod_s2 [4][3];
	logic signed [34:0]       t_s3 [3];
	logic [16:0]              q1_s4 [3];
	logic [18:0]              v2_s4 [3];
	coord_t                   cr_s4 [3];
	coord_t                   asm_q [3][3];
	logic                     sample_valid_q;
	sample_t                  sample_q;

	logic       last_idx, load;
	logic [6:0] div_shift;
	logic       div_ge;
	logic [7:0] ur_sum;
	coord_t     res [3];

	assign job_ready = (state_q == BK_IDLE);
	assign busy = (state_q != BK_IDLE);
	assign last_idx = (idx_q == job_q.frames - 1'b1);
	assign load = (state_q == BK_LOAD) && (!sample_valid_q || sample_ready);
	assign div_shift = {rem_q[5:0], (cnt_q == 5'd16)};
	assign div_ge = (div_shift >= job_q.frames);
	assign ur_sum = {1'b0, ur_q} + {1'b0, rem_q};
	assign sample_valid = sample_valid_q;
	assign sample = sample_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (job_valid) state_d = BK_DIV;
			BK_DIV: if (cnt_q == '0) state_d = BK_SQR;
			BK_SQR: state_d = BK_CUBE;
			BK_CUBE: state_d = BK_ORD;
			BK_ORD: if (ord_q == 2'd2) state_d = BK_DRAIN;
			BK_DRAIN: if (vld_s4 && ord_s4 == 2'd2) state_d = BK_LOAD;
			BK_LOAD: if (load) state_d = last_idx ? BK_IDLE : BK_SQR;
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			sample_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1 <= (state_q == BK_ORD);
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			if (load) begin
				sample_valid_q <= 1'b1;
			end else if (sample_ready) begin
				sample_valid_q <= 1'b0;
			end
		end
	end

	// segment setup, 65536 / frames by restoring division, then step u
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				job_q <= job;
				cnt_q <= 5'd16;
				rem_q <= '0;
				quo_q <= '0;
			end
			BK_DIV: begin
				rem_q <= div_ge ? div_shift - job_q.frames : div_shift;
				quo_q <= {quo_q[15:0], div_ge};
				cnt_q <= cnt_q - 1'b1;
				u_q <= '0;
				ur_q <= '0;
				idx_q <= '0;
			end
			BK_SQR: begin
				u2_q <= u_q[15:0] * u_q[15:0];
			end
			BK_CUBE: begin
				u3_q <= u2_q * u_q[15:0];
				ord_q <= '0;
			end
			BK_ORD: begin
				ord_q <= ord_q + 1'b1;
			end
			BK_DRAIN: begin
			end
			BK_LOAD: begin
				if (load) begin
					idx_q <= idx_q + 1'b1;
					if (ur_sum >= {1'b0, job_q.frames}) begin
						ur_q <= 7'(ur_sum - {1'b0, job_q.frames});
						u_q <= u_q + quo_q + 1'b1;
					end else begin
						ur_q <= ur_sum[6:0];
						u_q <= u_q + quo_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// evaluation pipeline, one basis order per issue
	always_ff @(posedge clk) begin
		ord_s1 <= ord_q;
		ord_s2 <= ord_s1;
		ord_s3 <= ord_s2;
		ord_s4 <= ord_s3;
		for (int m = 0; m < 4; m++) begin
			w_s1[m] <= weight_q24(job_q.mode, ord_q, 2'(m), u_q[15:0], u2_q, u3_q);
		end
		for (int m = 0; m < 4; m++) begin
			for (int k = 0; k < 3; k++) begin
				prod_s2[m][k] <= w_s1[m] * job_q.pts[m][k];
			end
		end
	end

	always_ff @(posedge clk) begin : scale_stages
		logic signed [65:0] s;
		logic signed [40:0] t;
		logic [33:0] v;
		logic [33:0] p1;
		logic [1:0]  r1;
		for (int k = 0; k < 3; k++) begin
			s = 66'(prod_s2[0][k]) + 66'(prod_s2[1][k]) + 66'(prod_s2[2][k])
				+ 66'(prod_s2[3][k]);
			if (job_q.mode == MODE_BSPLINE) begin
				t = 41'((s + 66'sd50331648) >>> 25);
				if (t < -41'sd6442450944) begin
					t_s3[k] <= -35'sd6442450944;
				end else if (t > 41'sd6442450943) begin
					t_s3[k] <= 35'sd6442450943;
				end else begin
					t_s3[k] <= t[34:0];
				end
			end else begin
				t = 41'((s + 66'sd16777216) >>> 25);
				if (t < -41'sd2147483648) begin
					t_s3[k] <= -35'sd2147483648;
				end else if (t > 41'sd2147483647) begin
					t_s3[k] <= 35'sd2147483647;
				end else begin
					t_s3[k] <= t[34:0];
				end
			end
		end
		for (int k = 0; k < 3; k++) begin
			v = 34'(t_s3[k] + 35'sd6442450944);
			p1 = v[33:17] * RECIP3_17;
			r1 = 2'(v[33:17] - 17'(p1[33:17] * 2'd3));
			q1_s4[k] <= p1[33:17];
			v2_s4[k] <= {r1, v[16:0]};
			cr_s4[k] <= t_s3[k][31:0];
		end
	end

	always_comb begin : final_scale
		logic [37:0] p2;
		logic [33:0] q;
		for (int k = 0; k < 3; k++) begin
			p2 = v2_s4[k] * RECIP3_20;
			q = {q1_s4[k], 17'b0} + 34'(p2[36:20]) - 34'h080000000;
			res[k] = (job_q.mode == MODE_BSPLINE) ? q[31:0] : cr_s4[k];
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s4) begin
			for (int k = 0; k < 3; k++) begin
				asm_q[ord_s4][k] <= res[k];
			end
		end
		if (load) begin
			sample_q.position_x <= asm_q[0][0];
			sample_q.position_y <= asm_q[0][1];
			sample_q.position_z <= asm_q[0][2];
			sample_q.tangent_x <= asm_q[1][0];
			sample_q.tangent_y <= asm_q[1][1];
			sample_q.tangent_z <= asm_q[1][2];
			sample_q.curvature_x <= asm_q[2][0];
			sample_q.curvature_y <= asm_q[2][1];
			sample_q.curvature_z <= asm_q[2][2];
			sample_q.last_sample <= last_idx;
		end
	end

endmodule

@@ dv/cubic_spline_point_evaluator_tb.sv @@
module cubic_spline_point_evaluator_tb
	import cspe_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	logic              clk;
	logic              arst_n;
	logic              point_valid;
	logic              point_ready;
	point_t            point;
	logic              sample_valid;
	logic              sample_ready;
	sample_t           sample;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	cubic_spline_point_evaluator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.point_valid  (point_valid),
		.point_ready  (point_ready),
		.point        (point),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// byte addresses of the two registers
	localparam logic [ADDR_W-1:0] ADDR_MODE   = ADDR_W'(4 * REG_MODE);
	localparam logic [ADDR_W-1:0] ADDR_FRAMES = ADDR_W'(4 * REG_FRAMES);

	// shadow of the block's settings and control point window
	logic                mode_shadow;
	logic [FRAMES_W-1:0] frames_shadow;
	coord_t              window [3][3];
	int                  points_held;

	sample_t expected_samples [$];
	int      error_count;
	int      points_sent;
	int      samples_checked;
	int      settings_used;
	bit      no_idle;        // when set neither side idles
	int      hold_cycles;    // long receiver hold-off requested by a test
	int      stall_left;

	initial begin
		clk = 1'b0;
	end
	always #6 clk = ~clk;

	// floor division for a positive divisor
	function automatic longint floor_div(longint a, longint d);
		longint q;
		q = a / d;
		if ((a % d) != 0 && a < 0)
			q = q - 1;
		return q;
	endfunction

	// basis weight at u (q0.16), rounded from the exact q.48 value to q.24
	function automatic longint basis_weight(logic mode, int ord, int pt, longint u);
		longint w;
		w = longint'(BASIS[mode][ord][pt][0]) * u * u * u
			+ longint'(BASIS[mode][ord][pt][1]) * u * u * 65536
			+ longint'(BASIS[mode][ord][pt][2]) * u * (64'sd1 <<< 32)
			+ longint'(BASIS[mode][ord][pt][3]) * (64'sd1 <<< 48);
		return floor_div(w + (64'sd1 <<< 23), 64'sd1 <<< 24);
	endfunction

	function automatic coord_t saturate(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return coord_t'(v);
	endfunction

	// queue the samples one control point causes and update the window
	task automatic predict_point(point_t p);
		coord_t  grp [4][3];
		coord_t  res [9];
		longint  wt [4];
		longint  den, u, acc;
		int      f;
		sample_t s;
		grp[3][0] = p.coord_x;
		grp[3][1] = p.coord_y;
		grp[3][2] = p.coord_z;
		if (points_held == 3) begin
			f = int'(frames_shadow);
			if (f < 1)
				f = 1;
			if (f > int'(MAX_FRAMES))
				f = int'(MAX_FRAMES);
			den = (mode_shadow == MODE_BSPLINE ? 6 : 2) * (64'sd1 <<< 24);
			for (int j = 0; j < 3; j++)
				for (int k = 0; k < 3; k++)
					grp[j][k] = window[j][k];
			for (int i = 0; i < f; i++) begin
				u = (longint'(i) <<< 16) / f;
				for (int o = 0; o < 3; o++) begin
					for (int m = 0; m < 4; m++)
						wt[m] = basis_weight(mode_shadow, o, m, u);
					for (int k = 0; k < 3; k++) begin
						acc = 0;
						for (int m = 0; m < 4; m++)
							acc += wt[m] * longint'(grp[m][k]);
						res[o * 3 + k] = saturate(floor_div(acc + den / 2, den));
					end
				end
				s.position_x  = res[0];
				s.position_y  = res[1];
				s.position_z  = res[2];
				s.tangent_x   = res[3];
				s.tangent_y   = res[4];
				s.tangent_z   = res[5];
				s.curvature_x = res[6];
				s.curvature_y = res[7];
				s.curvature_z = res[8];
				s.last_sample = (i == f - 1);
				expected_samples.push_back(s);
			end
			// slide the window by one point
			for (int j = 0; j < 3; j++)
				for (int k = 0; k < 3; k++)
					window[j][k] = grp[j + 1][k];
		end else begin
			for (int k = 0; k < 3; k++)
				window[points_held][k] = grp[3][k];
			points_held++;
		end
		if (p.final_point) begin
			for (int j = 0; j < 3; j++)
				for (int k = 0; k < 3; k++)
					window[j][k] = '0;
			points_held = 0;
		end
	endtask

	// idle length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// offer one control point and wait for its transfer
	task automatic send_point(coord_t x, coord_t y, coord_t z, logic fin);
		int gap;
		point_t p;
		gap = pick_gap();
		if (gap > 0) begin
			point_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		p.coord_x     = x;
		p.coord_y     = y;
		p.coord_z     = z;
		p.final_point = fin;
		point       <= p;
		point_valid <= 1'b1;
		@(posedge clk);
		while (!point_ready)
			@(posedge clk);
		predict_point(p);
		points_sent++;
	endtask

	task automatic stop_points();
		point_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic coord_t any_coord();
		case ($urandom_range(0, 3))
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
			default: return coord_t'($signed($urandom_range(0, 32'h1fffff)) - 32'sh100000);
		endcase
	endfunction

	// wait for every expected sample, then for the block to settle
	task automatic drain();
		stop_points();
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// setup, access, then idle with psel low before the next access
	task automatic apb_access(logic wr, logic [ADDR_W-1:0] addr, logic [31:0] data,
			output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// write both registers and read them back, block is idle here
	task automatic set_config(logic mode, logic [FRAMES_W-1:0] frames);
		logic [31:0] rd;
		apb_access(1'b1, ADDR_MODE, {$urandom} & ~32'h1 | 32'(mode), rd);
		apb_access(1'b1, ADDR_FRAMES, {$urandom} & ~32'h7f | 32'(frames), rd);
		mode_shadow   = mode;
		frames_shadow = frames;
		settings_used++;
		apb_access(1'b0, ADDR_MODE, '0, rd);
		if (rd[0] !== mode) begin
			$display("%0t: mode readback expected %0d actual %0d", $realtime, mode, rd[0]);
			error_count++;
		end
		apb_access(1'b0, ADDR_FRAMES, '0, rd);
		if (rd[FRAMES_W-1:0] !== frames) begin
			$display("%0t: frames readback expected %0d actual %0d", $realtime, frames,
				rd[FRAMES_W-1:0]);
			error_count++;
		end
		@(posedge clk);
	endtask

	// compare one sample transfer with the oldest expectation
	task automatic check_sample(sample_t got);
		sample_t exp;
		logic [$bits(sample_t)-1:0] gb, eb;
		string names [9] = '{"position_x", "position_y", "position_z", "tangent_x",
			"tangent_y", "tangent_z", "curvature_x", "curvature_y", "curvature_z"};
		if (expected_samples.size() == 0) begin
			$display("%0t: unexpected sample transfer, expected none actual %h",
				$realtime, got);
			error_count++;
			return;
		end
		exp = expected_samples.pop_front();
		gb = got;
		eb = exp;
		samples_checked++;
		for (int f = 0; f < 9; f++)
			if (gb[$bits(sample_t)-1-32*f -: 32] !== eb[$bits(sample_t)-1-32*f -: 32]) begin
				$display("%0t: %s expected %0d actual %0d", $realtime, names[f],
					$signed(eb[$bits(sample_t)-1-32*f -: 32]),
					$signed(gb[$bits(sample_t)-1-32*f -: 32]));
				error_count++;
			end
		if (got.last_sample !== exp.last_sample) begin
			$display("%0t: last_sample expected %0d actual %0d", $realtime,
				exp.last_sample, got.last_sample);
			error_count++;
		end
	endtask

	// sample side: check each transfer, then pick ready for the next cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && sample_ready)
				check_sample(sample);
			if (hold_cycles > 0) begin
				hold_cycles--;
				sample_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				sample_ready <= 1'b0;
			end else begin
				stall_left = pick_gap();
				sample_ready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// extremes of the coordinates, too few points, final points, reset settings
	task automatic test_directed();
		// final point while fewer than three are held gives nothing
		send_point(32'sh7fffffff, 32'sh80000000, 32'sh0, 1'b1);
		send_point(32'sh00010000, 32'sh0, 32'shffff0000, 1'b0);
		send_point(32'sh0, 32'sh0, 32'sh0, 1'b1);
		// four points at the extremes, final on the fourth
		send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1'b0);
		send_point(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b0);
		send_point(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0);
		send_point(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 1'b1);
		// ramp, window slides across three segments
		for (int i = 0; i < 6; i++)
			send_point(coord_t'(i * 32'sh10000), coord_t'(-i * 32'sh8000),
				coord_t'(i * i * 32'sh4000), i == 5);
		drain();
		set_config(MODE_BSPLINE, 7'd1);
		for (int i = 0; i < 5; i++)
			send_point(32'sh7fffffff, 32'sh80000000, coord_t'(i * 32'sh30000), i == 4);
		drain();
		// frame count zero acts as one, above the bound clamps to 64
		set_config(MODE_CATMULL, 7'd0);
		for (int i = 0; i < 4; i++)
			send_point(any_coord(), any_coord(), any_coord(), i == 3);
		drain();
		set_config(MODE_BSPLINE, 7'd127);
		for (int i = 0; i < 4; i++)
			send_point(any_coord(), any_coord(), any_coord(), i == 3);
		drain();
	endtask

	// random curves under a range of settings
	task automatic test_random(int n_points);
		int len;
		int sent;
		sent = 0;
		while (sent < n_points) begin
			set_config(1'($urandom), $urandom_range(0, 9) == 0 ? 7'd64 :
				$urandom_range(0, 9) == 0 ? 7'($urandom) : 7'($urandom_range(1, 8)));
			no_idle = ($urandom_range(0, 3) == 0);
			for (int c = 0; c < 3; c++) begin
				len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3)
					: $urandom_range(4, 9);
				for (int i = 0; i < len; i++)
					send_point(any_coord(), any_coord(), any_coord(),
						i == len - 1 || $urandom_range(0, 30) == 0);
				sent += len;
			end
			no_idle = 0;
			drain();
		end
	endtask

	// receiver holds off while points keep coming, input must stall
	task automatic test_backpressure();
		set_config(MODE_CATMULL, 7'd4);
		hold_cycles = 400;
		no_idle = 1;
		for (int i = 0; i < 12; i++)
			send_point(any_coord(), any_coord(), any_coord(), i == 11);
		no_idle = 0;
		drain();
	endtask

	initial begin
		arst_n       = 1'b0;
		point_valid  = 1'b0;
		point        = '0;
		sample_ready = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		mode_shadow   = 1'b0;
		frames_shadow = FRAMES_RESET;
		for (int j = 0; j < 3; j++)
			for (int k = 0; k < 3; k++)
				window[j][k] = '0;
		points_held     = 0;
		error_count     = 0;
		points_sent     = 0;
		samples_checked = 0;
		settings_used   = 0;
		no_idle         = 0;
		hold_cycles     = 0;
		stall_left      = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random(140);
		set_config(MODE_CATMULL, FRAMES_RESET);

		$display("covered %0d control points, %0d samples checked, %0d register settings",
			points_sent, samples_checked, settings_used);
		$display("both bases, frame counts from zero to beyond the bound, final-point clears");
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#60ms;
		$display("timeout with %0d samples outstanding", expected_samples.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule
